[rtl/dtq_pkg.sv]
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_START_TRK = 3'd1;
  localparam logic [2:0] MODE_START_UNT = 3'd2;
  localparam logic [2:0] MODE_CANCEL    = 3'd3;
  localparam logic [2:0] MODE_FLUSH     = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [63:0] dl;
    logic [31:0] id;
    logic [15:0] tag;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
    logic pop;
  } ctrl_t;

endpackage

[rtl/deadline_timer_queue_unit.sv]
`timescale 1ns / 1ps
// Deadline-ordered timer queue built as a chain of TABLE_DEPTH cells, one
// pending timer per cell, kept packed from cell 0 in firing order. A tracked
// start runs its cancel step and then the insert, an untracked start only the
// insert (or a reject when full), and a cancel runs the cancel step and then an
// ack; a tick or flush fires up to MAX_RESULTS timers per item (or acks if none
// is due), and an unused mode only acks. There is a single result register, and a
// stalled result register holds the sequencer until it frees. A new item is
// taken once the previous one has handed its last result to the result
// register.
module deadline_timer_queue_unit import dtq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] delay_ms,
  input  logic [31:0] old_id,
  input  logic [15:0] tag,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [31:0] timer_id,
  output logic [15:0] fired_tag,
  output logic        last
);

  localparam int CNT_W = $clog2(MAX_RESULTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CANCEL = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_FIRE   = 3'd3;
  localparam logic [2:0] S_ACK    = 3'd4;

  logic [2:0]       state;
  logic [2:0]       cur_mode;
  logic             fire_all;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      now_ms;
  logic [31:0]      id_counter;
  logic [63:0]      ins_dl;
  logic [31:0]      cur_old_id;
  logic [15:0]      cur_tag;

  ctrl_t            ctrl;
  logic [63:0]      key_dl;
  entry_t           new_ent;
  entry_t           ent_q   [TABLE_DEPTH];
  logic             valid_q [TABLE_DEPTH];
  logic             le_q    [TABLE_DEPTH];
  logic             pfx_q   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vvec;

  logic        out_free;
  logic        emit;
  logic [1:0]  e_kind;
  logic [31:0] e_id;
  logic [15:0] e_tag;
  logic        e_last;
  logic        head_ok;
  logic        next_ok;
  logic        full;
  logic [31:0] id_inc;
  logic [31:0] nid;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign key_dl     = (state == S_FIRE) ? now_ms : ins_dl;
  assign full       = valid_q[TABLE_DEPTH-1];
  assign id_inc     = id_counter + 32'd1;
  assign nid        = (id_inc == 32'd0) ? 32'd1 : id_inc;
  assign head_ok    = valid_q[0] && (fire_all || le_q[0]);
  assign next_ok    = valid_q[1] && (fire_all || le_q[1]);

  always_comb begin
    new_ent.dl  = ins_dl;
    new_ent.id  = (cur_mode == MODE_START_TRK) ? nid : 32'd0;
    new_ent.tag = cur_tag;
  end

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t l_ent;
    logic   l_valid;
    logic   l_le;
    logic   l_pfx;
    entry_t r_ent;
    logic   r_valid;
    if (i == 0) begin : g_first
      assign l_ent   = new_ent;
      assign l_valid = 1'b1;
      assign l_le    = 1'b0;
      assign l_pfx   = 1'b0;
    end else begin : g_mid
      assign l_ent   = ent_q[i-1];
      assign l_valid = valid_q[i-1];
      assign l_le    = le_q[i-1];
      assign l_pfx   = pfx_q[i-1];
    end
    if (i == TABLE_DEPTH-1) begin : g_end
      assign r_ent   = new_ent;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_ent   = ent_q[i+1];
      assign r_valid = valid_q[i+1];
    end
    dtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key_dl     (key_dl),
      .key_id     (cur_old_id),
      .new_ent    (new_ent),
      .left_ent   (l_ent),
      .left_valid (l_valid),
      .left_le    (l_le),
      .pfx_in     (l_pfx),
      .right_ent  (r_ent),
      .right_valid(r_valid),
      .ent        (ent_q[i]),
      .valid      (valid_q[i]),
      .le         (le_q[i]),
      .pfx_out    (pfx_q[i])
    );
    assign vvec[i] = valid_q[i];
  end

  // sequencer outputs
  always_comb begin
    ctrl   = '0;
    emit   = 1'b0;
    e_kind = KIND_ACK;
    e_id   = 32'd0;
    e_tag  = 16'd0;
    e_last = 1'b1;
    unique case (state)
      S_CANCEL: begin
        ctrl.del = (cur_old_id != 32'd0);
      end
      S_START: begin
        if (out_free) begin
          emit = 1'b1;
          if (full) begin
            e_kind = KIND_REJECT;
          end else begin
            ctrl.ins = 1'b1;
            if (cur_mode == MODE_START_TRK) begin
              e_id = nid;
            end
          end
        end
      end
      S_FIRE: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_ok) begin
            ctrl.pop = 1'b1;
            e_kind   = KIND_FIRED;
            e_id     = ent_q[0].id;
            e_tag    = ent_q[0].tag;
            e_last   = (cnt == CNT_W'(MAX_RESULTS-1)) || !next_ok;
          end
        end
      end
      S_ACK: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_ms     <= 64'd0;
      id_counter <= 32'd0;
      cnt        <= '0;
      fire_all   <= 1'b0;
      cur_mode   <= MODE_TICK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_mode <= mode;
            cnt      <= '0;
            unique case (mode)
              MODE_TICK: begin
                now_ms   <= now_ms + 64'd1;
                fire_all <= 1'b0;
                state    <= S_FIRE;
              end
              MODE_FLUSH: begin
                fire_all <= 1'b1;
                state    <= S_FIRE;
              end
              MODE_START_TRK: state <= S_CANCEL;
              MODE_CANCEL:    state <= S_CANCEL;
              MODE_START_UNT: state <= S_START;
              default:        state <= S_ACK;
            endcase
          end
        end
        S_CANCEL: begin
          state <= (cur_mode == MODE_START_TRK) ? S_START : S_ACK;
        end
        S_START: begin
          if (emit) begin
            if (ctrl.ins && (cur_mode == MODE_START_TRK)) begin
              id_counter <= nid;
            end
            state <= S_IDLE;
          end
        end
        S_FIRE: begin
          if (emit) begin
            cnt <= cnt + CNT_W'(1);
            if (e_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_ACK: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      ins_dl     <= now_ms + {32'd0, delay_ms};
      cur_old_id <= old_id;
      cur_tag    <= tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind      <= e_kind;
      timer_id  <= e_id;
      fired_tag <= e_tag;
      last      <= e_last;
    end
  end

`ifndef SYNTHESIS
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.ins, ctrl.del, ctrl.pop}))
    else $error("more than one chain operation at once");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((vvec + TABLE_DEPTH'(1)) & vvec) == '0)
    else $error("valid cells not packed from cell 0");

  a_no_ins_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |-> !full)
    else $error("insert into full table");

  a_fire_head: assert property (@(posedge clk) disable iff (rst)
    (emit && e_kind == KIND_FIRED) |-> valid_q[0])
    else $error("fired item from empty head cell");
`endif

endmodule

[rtl/dtq_cell.sv]
`timescale 1ns / 1ps
module dtq_cell import dtq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [63:0] key_dl,
  input  logic [31:0] key_id,
  input  entry_t      new_ent,
  input  entry_t      left_ent,
  input  logic        left_valid,
  input  logic        left_le,
  input  logic        pfx_in,
  input  entry_t      right_ent,
  input  logic        right_valid,
  output entry_t      ent,
  output logic        valid,
  output logic        le,
  output logic        pfx_out
);

  logic match;

  assign le      = valid && (ent.dl <= key_dl);
  assign match   = valid && (ent.id == key_id);
  assign pfx_out = pfx_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (ctrl.pop) begin
        valid <= right_valid;
      end else if (ctrl.del && pfx_out) begin
        valid <= right_valid;
      end else if (ctrl.ins && !le) begin
        valid <= valid | left_valid;
      end else begin
        valid <= valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.pop) begin
      ent <= right_ent;
    end else if (ctrl.del && pfx_out) begin
      ent <= right_ent;
    end else if (ctrl.ins && !le) begin
      ent <= left_le ? new_ent : left_ent;
    end else begin
      ent <= ent;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import dtq_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_CYCLES = 40;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_id;
    logic [15:0] fired_tag;
    logic        last;
  } res_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] delay;
    logic [31:0] old;
    logic [15:0] tag;
    bit          pinned;
    res_t        res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [2:0]  mode = '0;
  logic [31:0] delay_ms = '0;
  logic [31:0] old_id = '0;
  logic [15:0] tag = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] timer_id;
  logic [15:0] fired_tag;
  logic        last;

  // pinned expectation travels with the item it belongs to
  bit   pin_on = 1'b0;
  res_t pin_res = '0;

  logic [63:0] now_ms = '0;
  logic [31:0] id_ctr = '0;
  entry_t      timers_q[$];
  res_t        awaited_q[$];
  int          fails = 0;
  int          cycle_cnt = 0;
  int          src_calm = 0;

  deadline_timer_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .mode(mode),
    .delay_ms(delay_ms),
    .old_id(old_id),
    .tag(tag),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .kind(kind),
    .timer_id(timer_id),
    .fired_tag(fired_tag),
    .last(last)
  );

  always #5 clk = ~clk;

  task automatic push_single(input logic [1:0] k, input logic [31:0] id);
    res_t r;
    r = '{kind: k, timer_id: id, fired_tag: 16'd0, last: 1'b1};
    awaited_q.push_back(r);
  endtask

  task automatic drop_timer(input logic [31:0] oid);
    if (oid == 32'd0) return;
    for (int i = 0; i < timers_q.size(); i++) begin
      if (timers_q[i].id == oid) begin
        timers_q.delete(i);
        return;
      end
    end
  endtask

  task automatic place_timer(input logic [63:0] dl, input logic [31:0] id,
                             input logic [15:0] tg);
    int     pos;
    entry_t e;
    pos = 0;
    while (pos < timers_q.size() && timers_q[pos].dl <= dl) pos++;
    e.dl = dl;
    e.id = id;
    e.tag = tg;
    timers_q.insert(pos, e);
  endtask

  task automatic fire_due(input bit all);
    int   n;
    res_t r;
    n = 0;
    while (n < MAX_RESULTS && n < timers_q.size() && (all || timers_q[n].dl <= now_ms)) n++;
    if (n == 0) begin
      push_single(KIND_ACK, 32'd0);
      return;
    end
    for (int i = 0; i < n; i++) begin
      r = '{kind: KIND_FIRED, timer_id: timers_q[0].id, fired_tag: timers_q[0].tag,
            last: (i == n - 1)};
      awaited_q.push_back(r);
      void'(timers_q.pop_front());
    end
  endtask

  task automatic advance_timer_table(input logic [2:0] md, input logic [31:0] dly,
                                     input logic [31:0] oid, input logic [15:0] tg);
    logic [63:0] dl;
    dl = now_ms + {32'd0, dly};
    case (md)
      MODE_TICK: begin
        now_ms = now_ms + 64'd1;
        fire_due(1'b0);
      end
      MODE_START_TRK: begin
        drop_timer(oid);
        if (timers_q.size() >= TABLE_DEPTH) begin
          push_single(KIND_REJECT, 32'd0);
        end else begin
          id_ctr = id_ctr + 32'd1;
          if (id_ctr == 32'd0) id_ctr = 32'd1;
          place_timer(dl, id_ctr, tg);
          push_single(KIND_ACK, id_ctr);
        end
      end
      MODE_START_UNT: begin
        if (timers_q.size() >= TABLE_DEPTH) begin
          push_single(KIND_REJECT, 32'd0);
        end else begin
          place_timer(dl, 32'd0, tg);
          push_single(KIND_ACK, 32'd0);
        end
      end
      MODE_CANCEL: begin
        drop_timer(oid);
        push_single(KIND_ACK, 32'd0);
      end
      MODE_FLUSH: fire_due(1'b1);
      default: push_single(KIND_ACK, 32'd0);
    endcase
  endtask

  function automatic logic [31:0] live_id();
    logic [31:0] ids[$];
    foreach (timers_q[i]) if (timers_q[i].id != 32'd0) ids.push_back(timers_q[i].id);
    if (ids.size() == 0) return $urandom();
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function automatic stim_row_t row_of(input logic [2:0] md, input logic [31:0] dly,
                                       input logic [31:0] oid, input logic [15:0] tg,
                                       input bit pinned, input res_t res);
    stim_row_t s;
    s.mode = md;
    s.delay = dly;
    s.old = oid;
    s.tag = tg;
    s.pinned = pinned;
    s.res = res;
    return s;
  endfunction

  task automatic offer_item(input stim_row_t s);
    int gap;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) src_calm = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= s.mode;
    delay_ms <= s.delay;
    old_id <= s.old;
    tag <= s.tag;
    pin_on <= s.pinned;
    pin_res <= s.res;
    do @(posedge clk); while (!item_ready);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        advance_timer_table(mode, delay_ms, old_id, tag);
        if (pin_on) begin
          void'(awaited_q.pop_back());
          awaited_q.push_back(pin_res);
        end
      end
      if (result_valid && result_ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected result: kind %0d timer_id %0d fired_tag %0d last %0d",
                 kind, timer_id, fired_tag, last);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            fails++;
          end
          if (timer_id !== want.timer_id) begin
            $error("timer_id: expected %0d, actual %0d", want.timer_id, timer_id);
            fails++;
          end
          if (fired_tag !== want.fired_tag) begin
            $error("fired_tag: expected %0d, actual %0d", want.fired_tag, fired_tag);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fails++;
          end
        end
      end
    end
  end

  initial begin : sink
    int stall;
    int calm;
    calm = 0;
    forever begin
      if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 40);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin : source
    stim_row_t   dir_tab[$];
    stim_row_t   s;
    res_t        ack;
    res_t        full;
    res_t        none;
    int          pick;
    logic [31:0] dly_pick[3];

    ack = '{kind: KIND_ACK, timer_id: 32'd0, fired_tag: 16'd0, last: 1'b1};
    full = '{kind: KIND_REJECT, timer_id: 32'd0, fired_tag: 16'd0, last: 1'b1};
    none = '0;
    dly_pick = '{32'd3, 32'd0, 32'd7};

    // empty table, idle ops, first ids, cancel before restart
    dir_tab.push_back(row_of(MODE_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, ack));
    dir_tab.push_back(row_of(MODE_CANCEL, 32'd0, 32'd0, 16'd0, 1, ack));
    dir_tab.push_back(row_of(MODE_SPARE_HI, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, ack));
    dir_tab.push_back(row_of(MODE_SPARE_LO, 32'd0, 32'd1, 16'd0, 1, ack));
    dir_tab.push_back(row_of(MODE_START_TRK, 32'd0, 32'd0, 16'hFFFF, 1,
                             '{KIND_ACK, 32'd1, 16'd0, 1'b1}));
    dir_tab.push_back(row_of(MODE_START_TRK, 32'd1, 32'd0, 16'h1234, 1,
                             '{KIND_ACK, 32'd2, 16'd0, 1'b1}));
    dir_tab.push_back(row_of(MODE_START_TRK, 32'd1, 32'd2, 16'hAAAA, 1,
                             '{KIND_ACK, 32'd3, 16'd0, 1'b1}));
    dir_tab.push_back(row_of(MODE_START_UNT, 32'hFFFFFFFF, 32'd0, 16'h0000, 1, ack));
    dir_tab.push_back(row_of(MODE_TICK, 32'd0, 32'd0, 16'd0, 0, none));
    // fill to capacity with equal and mixed deadlines
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      dir_tab.push_back(row_of((i % 4 == 3) ? MODE_START_UNT : MODE_START_TRK,
                               dly_pick[i % 3], 32'd0, 16'h0100 + i[15:0], 0, none));
    dir_tab.push_back(row_of(MODE_START_UNT, 32'd5, 32'd0, 16'h5555, 1, full));
    dir_tab.push_back(row_of(MODE_START_TRK, 32'd2, 32'd4, 16'h5A5A, 0, none));
    dir_tab.push_back(row_of(MODE_FLUSH, 32'd0, 32'd0, 16'd0, 0, none));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer_item(dir_tab[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      s = row_of(MODE_TICK, $urandom(), $urandom(), 16'($urandom()), 0, none);
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        s.mode = $urandom_range(0, 1) ? MODE_START_TRK : MODE_START_UNT;
        case ($urandom_range(0, 6))
          0: s.delay = $urandom();
          1: s.delay = $urandom_range(0, 200);
          default: s.delay = $urandom_range(0, 24);
        endcase
        case ($urandom_range(0, 6))
          0, 1, 2: s.old = 32'd0;
          3, 4, 5: s.old = live_id();
          default: s.old = $urandom();
        endcase
      end else if (pick < 72) begin
        s.mode = MODE_TICK;
      end else if (pick < 84) begin
        s.mode = MODE_CANCEL;
        case ($urandom_range(0, 6))
          0: s.old = 32'd0;
          1: s.old = $urandom();
          default: s.old = live_id();
        endcase
      end else if (pick < 89) begin
        s.mode = MODE_FLUSH;
      end else if (pick < 93) begin
        s.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else begin
        s.mode = MODE_TICK;
      end
      offer_item(s);
    end
    item_valid <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/deadline_timer_queue_unit.sv
sim/tb.sv
